FILE: hw/rtl/rbbr_pkg.sv
// Shared constants, codes and controller/datapath interface types of the ring buffer bit reader.
package rbbr_pkg;

  localparam int unsigned BufferDepthDefault = 4096;
  localparam int unsigned IndexSpan          = 4096;

  localparam int unsigned IndexW  = 12;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned NbitsW  = 5;
  localparam int unsigned OffsetW = 16;
  localparam int unsigned ValueW  = 24;
  localparam int unsigned CountW  = 21;
  localparam int unsigned SizeW   = 13;
  localparam int unsigned BitPosW = 3;

  localparam logic [SizeW-1:0]  SizeReset = SizeW'(4096);
  localparam logic [NbitsW-1:0] ReadLimit = NbitsW'(25);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_READ    = 2'd2,
    OP_WIND    = 2'd3
  } op_e;

  typedef struct packed {
    logic latch;
    logic load;
    logic restart;
    logic rd_init;
    logic rd_shift;
    logic wind_init;
    logic wind_step;
    logic wind_fix;
  } rbbr_cmd_t;

  typedef struct packed {
    op_e  op;
    logic rd_skip;
    logic wind_zero;
    logic pos_neg;
    logic step_last;
  } rbbr_sts_t;

endpackage

FILE: hw/rtl/rbbr_ram.sv
// Generic single-port RAM with registered read data.
module rbbr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rbbr_ctrl.sv
// Controller state machine of the ring buffer bit reader.
module rbbr_ctrl
  import rbbr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  rbbr_sts_t sts_i,
  output rbbr_cmd_t cmd_o,
  output logic      busy_o,
  output logic      done_o
);

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_DISPATCH = 6'b000010,
    ST_RD_SHIFT = 6'b000100,
    ST_W_STEP   = 6'b001000,
    ST_W_FIX    = 6'b010000,
    ST_DONE     = 6'b100000
  } state_e;

  state_e    state_q, state_d;
  rbbr_cmd_t cmd;

  always_comb begin
    state_d = state_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE, ST_DONE: begin
        if (start_i) begin
          cmd.latch = 1'b1;
          state_d   = ST_DISPATCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DISPATCH: begin
        unique case (sts_i.op)
          OP_LOAD: begin
            cmd.load = 1'b1;
            state_d  = ST_DONE;
          end
          OP_RESTART: begin
            cmd.restart = 1'b1;
            state_d     = ST_DONE;
          end
          OP_READ: begin
            if (sts_i.rd_skip) begin
              state_d = ST_DONE;
            end else begin
              cmd.rd_init = 1'b1;
              state_d     = ST_RD_SHIFT;
            end
          end
          OP_WIND: begin
            if (sts_i.wind_zero) begin
              state_d = ST_DONE;
            end else begin
              cmd.wind_init = 1'b1;
              state_d       = ST_W_STEP;
            end
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_RD_SHIFT: begin
        cmd.rd_shift = 1'b1;
        if (!sts_i.pos_neg) begin
          state_d = ST_DONE;
        end
      end
      ST_W_STEP: begin
        cmd.wind_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = ST_W_FIX;
        end
      end
      ST_W_FIX: begin
        cmd.wind_fix = 1'b1;
        state_d      = ST_DONE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy_o = !((state_q == ST_IDLE) || (state_q == ST_DONE));
  assign done_o = (state_q == ST_DONE);

endmodule

FILE: hw/rtl/rbbr_dp.sv
// Datapath of the ring buffer bit reader: pointers, bit count, byte store and wind reduction.
module rbbr_dp
  import rbbr_pkg::*;
#(
  parameter int unsigned BufferDepth = BufferDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rbbr_cmd_t                 cmd_i,
  output rbbr_sts_t                 sts_o,
  input  logic                      cfg_we_i,
  input  logic [SizeW-1:0]          cfg_data_i,
  input  logic [1:0]                operation_i,
  input  logic [IndexW-1:0]         byte_index_i,
  input  logic [ByteW-1:0]          byte_value_i,
  input  logic [NbitsW-1:0]         bits_to_read_i,
  input  logic signed [OffsetW-1:0] wind_offset_i,
  output logic [ValueW-1:0]         read_value_o,
  output logic signed [CountW-1:0]  bits_available_o,
  output logic [IndexW-1:0]         read_byte_position_o,
  output logic [BitPosW-1:0]        read_bit_position_o
);

  localparam int unsigned AddrW = $clog2(BufferDepth);
  localparam int unsigned WideW = (AddrW > IndexW) ? AddrW : IndexW;
  localparam int unsigned LimitInt = (BufferDepth < IndexSpan) ? BufferDepth : IndexSpan;
  localparam logic [SizeW-1:0] SizeLimit = SizeW'(LimitInt);
  localparam logic [WideW:0] DepthWide = (WideW + 1)'(BufferDepth);
  localparam int unsigned DivW = SizeW + 13;

  function automatic logic [AddrW-1:0] to_addr(input logic [IndexW-1:0] idx);
    logic [WideW-1:0] tmp;
    tmp = WideW'(idx);
    return tmp[AddrW-1:0];
  endfunction

  function automatic logic signed [CountW-1:0] sat_add(input logic signed [CountW-1:0] c,
                                                       input logic signed [16:0] dlt);
    logic signed [CountW:0] s;
    s = $signed({c[CountW-1], c}) + $signed({{(CountW - 16){dlt[16]}}, dlt});
    if (s[CountW] != s[CountW-1]) begin
      return s[CountW] ? {1'b1, {(CountW - 1){1'b0}}} : {1'b0, {(CountW - 1){1'b1}}};
    end
    return s[CountW-1:0];
  endfunction

  logic [SizeW-1:0]          size_q;
  logic [1:0]                op_q;
  logic [IndexW-1:0]         idx_in_q;
  logic [ByteW-1:0]          val_in_q;
  logic [NbitsW-1:0]         n_q;
  logic signed [OffsetW-1:0] off_q;

  logic [IndexW-1:0]         read_index_q, read_index_d;
  logic [BitPosW-1:0]        bitpos_q, bitpos_d;
  logic signed [CountW-1:0]  count_q, count_d;
  logic [3:0]                k_q, k_d;

  logic [ValueW-1:0]         value_q, value_d;
  logic [31:0]               acc_q, acc_d;
  logic signed [5:0]         pos_q, pos_d;
  logic [13:0]               r_q, r_d;
  logic                      neg_q, neg_d;
  logic [DivW-1:0]           dv_q, dv_d;

  logic [SizeW-1:0]          size_eff;
  logic [IndexW-1:0]         idx_next;
  logic [SizeW-1:0]          idx_inc;
  logic                      ram_we;
  logic [AddrW-1:0]          ram_addr;
  logic [ByteW-1:0]          ram_rdata;
  logic [31:0]               acc_new;
  logic [3:0]                sh_amt;
  logic [31:0]               rd_mask;
  logic [31:0]               shifted;
  logic signed [17:0]        wind_p;
  logic signed [17:0]        wind_bytes;
  logic signed [17:0]        wind_t;
  logic [17:0]               wind_mag;

  always_comb begin
    if (size_q == '0) begin
      size_eff = SizeW'(1);
    end else if (size_q > SizeLimit) begin
      size_eff = SizeLimit;
    end else begin
      size_eff = size_q;
    end
  end

  assign idx_inc  = SizeW'(read_index_q) + SizeW'(1);
  assign idx_next = (idx_inc >= size_eff) ? '0 : idx_inc[IndexW-1:0];

  assign ram_we = cmd_i.load && ((WideW + 1)'(idx_in_q) < DepthWide);

  always_comb begin
    if (cmd_i.load) begin
      ram_addr = to_addr(idx_in_q);
    end else if (cmd_i.rd_shift) begin
      ram_addr = to_addr(idx_next);
    end else begin
      ram_addr = to_addr(read_index_q);
    end
  end

  rbbr_ram #(
    .Width (ByteW),
    .Depth (BufferDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (val_in_q),
    .rdata_o (ram_rdata)
  );

  assign acc_new = {acc_q[23:0], ram_rdata};
  assign sh_amt  = 4'(pos_q[2:0]) + 4'd1;
  assign rd_mask = (32'd1 << n_q) - 32'd1;
  assign shifted = acc_new >> sh_amt;

  assign wind_p     = $signed({15'b0, bitpos_q}) - $signed({{2{off_q[OffsetW-1]}}, off_q});
  assign wind_bytes = wind_p >>> 3;
  assign wind_t     = $signed({6'b0, read_index_q}) - wind_bytes;
  assign wind_mag   = wind_t[17] ? 18'(-wind_t) : 18'(wind_t);

  always_comb begin
    read_index_d = read_index_q;
    bitpos_d     = bitpos_q;
    count_d      = count_q;
    k_d          = k_q;
    value_d      = value_q;
    acc_d        = acc_q;
    pos_d        = pos_q;
    r_d          = r_q;
    neg_d        = neg_q;
    dv_d         = dv_q;

    if (cmd_i.latch) begin
      value_d = '0;
    end
    if (cmd_i.load) begin
      count_d = sat_add(count_q, 17'sd8);
    end
    if (cmd_i.restart) begin
      read_index_d = '0;
      bitpos_d     = BitPosW'(7);
      count_d      = '0;
    end
    if (cmd_i.rd_init) begin
      count_d = sat_add(count_q, -$signed({12'b0, n_q}));
      pos_d   = $signed({3'b0, bitpos_q}) - $signed({1'b0, n_q});
      acc_d   = '0;
    end
    if (cmd_i.rd_shift) begin
      acc_d = acc_new;
      if (pos_q[5]) begin
        pos_d        = pos_q + 6'sd8;
        read_index_d = idx_next;
      end else begin
        bitpos_d = pos_q[2:0];
        value_d  = ValueW'(shifted & rd_mask);
      end
    end
    if (cmd_i.wind_init) begin
      count_d  = sat_add(count_q, -$signed({off_q[OffsetW-1], off_q}));
      bitpos_d = wind_p[2:0];
      neg_d    = wind_t[17];
      r_d      = wind_mag[13:0];
      dv_d     = {size_eff, 13'b0};
      k_d      = 4'd13;
    end
    if (cmd_i.wind_step) begin
      if (DivW'(r_q) >= dv_q) begin
        r_d = r_q - dv_q[13:0];
      end
      dv_d = dv_q >> 1;
      k_d  = k_q - 4'd1;
    end
    if (cmd_i.wind_fix) begin
      if (neg_q && (r_q != '0)) begin
        read_index_d = IndexW'(size_eff - SizeW'(r_q));
      end else begin
        read_index_d = r_q[IndexW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q       <= SizeReset;
      read_index_q <= '0;
      bitpos_q     <= BitPosW'(7);
      count_q      <= '0;
      k_q          <= '0;
    end else begin
      if (cfg_we_i) begin
        size_q <= cfg_data_i;
      end
      read_index_q <= read_index_d;
      bitpos_q     <= bitpos_d;
      count_q      <= count_d;
      k_q          <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q     <= operation_i;
      idx_in_q <= byte_index_i;
      val_in_q <= byte_value_i;
      n_q      <= bits_to_read_i;
      off_q    <= wind_offset_i;
    end
    value_q <= value_d;
    acc_q   <= acc_d;
    pos_q   <= pos_d;
    r_q     <= r_d;
    neg_q   <= neg_d;
    dv_q    <= dv_d;
  end

  assign sts_o.op        = op_e'(op_q);
  assign sts_o.rd_skip   = (n_q == '0) || (n_q >= ReadLimit);
  assign sts_o.wind_zero = (off_q == '0);
  assign sts_o.pos_neg   = pos_q[5];
  assign sts_o.step_last = (k_q == '0);

  assign read_value_o         = value_q;
  assign bits_available_o     = count_q;
  assign read_byte_position_o = read_index_q;
  assign read_bit_position_o  = bitpos_q;

endmodule

FILE: hw/rtl/ring_buffer_bit_reader.sv
// Top level of the ring buffer bit reader: controller and datapath.
//
// A transaction is taken at a rising edge with start high and busy low; the
// operation selects a byte load, a restart, a read of 1 to 24 bits (MSB
// first) or a wind of the read point by a signed bit offset. Each transaction
// gives one result on the result ports for one cycle, marked by done_o; the
// receiver cannot hold it off. The ports show the read value and the count,
// byte index and bit position after the transaction.
// After the accepting edge a transaction passes a dispatch state; a load, a
// restart, an ignored read or a zero wind then ends in the done state; a read
// first shifts in the 1 to 4 bytes it touches, as the single-port store
// delivers one byte per cycle; a wind first runs the modulo reduction of the
// new byte index, one conditional subtract per cycle over 14 steps, then a
// fix step. busy is low in the done cycle, so the next transaction may be taken there.
// The user writes the buffer size register with cfg_we_i only while idle; the
// block does not enforce it. Reset sets the size to 4096, the pointers to
// byte 0, bit 7 and the count to zero; store contents are undefined until written.
module ring_buffer_bit_reader
  import rbbr_pkg::*;
#(
  parameter int unsigned BufferDepth = BufferDepthDefault
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                operation_i,
  input  logic [IndexW-1:0]         byte_index_i,
  input  logic [ByteW-1:0]          byte_value_i,
  input  logic [NbitsW-1:0]         bits_to_read_i,
  input  logic signed [OffsetW-1:0] wind_offset_i,
  input  logic                      cfg_we_i,
  input  logic [SizeW-1:0]          cfg_data_i,
  output logic                      done_o,
  output logic [ValueW-1:0]         read_value_o,
  output logic signed [CountW-1:0]  bits_available_o,
  output logic [IndexW-1:0]         read_byte_position_o,
  output logic [BitPosW-1:0]        read_bit_position_o
);

  rbbr_cmd_t cmd;
  rbbr_sts_t sts;

  rbbr_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  rbbr_dp #(
    .BufferDepth (BufferDepth)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .operation_i          (operation_i),
    .byte_index_i         (byte_index_i),
    .byte_value_i         (byte_value_i),
    .bits_to_read_i       (bits_to_read_i),
    .wind_offset_i        (wind_offset_i),
    .read_value_o         (read_value_o),
    .bits_available_o     (bits_available_o),
    .read_byte_position_o (read_byte_position_o),
    .read_bit_position_o  (read_bit_position_o)
  );

endmodule

FILE: sim/ring_buffer_bit_reader_tb.sv
// Self-checking testbench of the ring buffer bit reader: directed and random transactions.
module ring_buffer_bit_reader_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rbbr_pkg::*;

  localparam int ClkHalf     = 4;
  localparam int QuietLimit  = 2000;
  localparam int ReportLimit = 10;
  localparam int SettleCycles = 4;
  localparam int DrainCycles = 24;
  localparam int PhaseBudget = 110;
  localparam int SweepLength = 40;
  localparam int CountHigh   = 1048575;
  localparam int CountLow    = -1048576;

  typedef enum logic [1:0] {ENTRY_CMD, ENTRY_CFG, ENTRY_DRAIN} entry_kind_e;

  typedef struct packed {
    op_e                        op;
    logic [IndexW-1:0]          addr;
    logic [ByteW-1:0]           data;
    logic [NbitsW-1:0]          nbits;
    logic signed [OffsetW-1:0]  offset;
  } cmd_t;

  typedef struct packed {
    entry_kind_e       kind;
    cmd_t              cmd;
    logic [SizeW-1:0]  size;
  } entry_t;

  typedef struct packed {
    logic [IndexW-1:0]         idx;
    logic [BitPosW-1:0]        bitpos;
    logic signed [CountW-1:0]  count;
  } ptr_t;

  typedef struct packed {
    logic [ValueW-1:0]         value;
    logic signed [CountW-1:0]  count;
    logic [IndexW-1:0]         idx;
    logic [BitPosW-1:0]        bitpos;
  } status_t;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      start;
  logic                      busy;
  logic [1:0]                operation_i;
  logic [IndexW-1:0]         byte_index_i;
  logic [ByteW-1:0]          byte_value_i;
  logic [NbitsW-1:0]         bits_to_read_i;
  logic signed [OffsetW-1:0] wind_offset_i;
  logic                      cfg_we_i;
  logic [SizeW-1:0]          cfg_data_i;
  logic                      done_o;
  logic [ValueW-1:0]         read_value_o;
  logic signed [CountW-1:0]  bits_available_o;
  logic [IndexW-1:0]         read_byte_position_o;
  logic [BitPosW-1:0]        read_bit_position_o;

  entry_t  cmd_backlog[$];
  status_t expected_status[$];

  ptr_t             plan_ptr;
  logic [SizeW-1:0] plan_size;
  bit               written[IndexSpan];
  int               planned;

  ptr_t             model_ptr;
  logic [SizeW-1:0] model_size;
  logic [ByteW-1:0] model_mem[IndexSpan];

  int sent_cnt;
  int acc_cnt;
  int gap_left;
  int steady_left;
  int settle;
  int quiet;
  int mismatches;
  int op_seen[4];
  int cfg_writes;
  bit hit_high;
  bit hit_low;

  ring_buffer_bit_reader dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .start                (start),
    .busy                 (busy),
    .operation_i          (operation_i),
    .byte_index_i         (byte_index_i),
    .byte_value_i         (byte_value_i),
    .bits_to_read_i       (bits_to_read_i),
    .wind_offset_i        (wind_offset_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_data_i           (cfg_data_i),
    .done_o               (done_o),
    .read_value_o         (read_value_o),
    .bits_available_o     (bits_available_o),
    .read_byte_position_o (read_byte_position_o),
    .read_bit_position_o  (read_bit_position_o)
  );

  function automatic logic [SizeW-1:0] wrap_size(logic [SizeW-1:0] reg_val);
    if (reg_val == '0) return SizeW'(1);
    if (reg_val > SizeW'(IndexSpan)) return SizeW'(IndexSpan);
    return reg_val;
  endfunction

  function automatic logic [IndexW-1:0] next_byte(logic [IndexW-1:0] idx,
                                                  logic [SizeW-1:0] size);
    logic [SizeW-1:0] nxt;
    nxt = {1'b0, idx} + SizeW'(1);
    return (nxt >= size) ? '0 : nxt[IndexW-1:0];
  endfunction

  function automatic bit read_takes(logic [NbitsW-1:0] n);
    return n != '0 && n < ReadLimit;
  endfunction

  function automatic int bytes_spanned(logic [BitPosW-1:0] bitpos, logic [NbitsW-1:0] n);
    int pos;
    int cnt;
    pos = int'(bitpos) - int'(n);
    cnt = 1;
    while (pos < 0) begin
      pos += 8;
      cnt++;
    end
    return cnt;
  endfunction

  function automatic logic signed [CountW-1:0] sat_add(logic signed [CountW-1:0] c, int delta);
    int sum;
    sum = int'(c) + delta;
    if (sum > CountHigh) sum = CountHigh;
    if (sum < CountLow) sum = CountLow;
    return CountW'(sum);
  endfunction

  // Pointer and count after one transaction; the read value is formed by the caller.
  function automatic ptr_t reader_advance(ptr_t s, logic [SizeW-1:0] size_reg, cmd_t c);
    ptr_t r;
    logic [SizeW-1:0] size;
    int pos;
    int p;
    int nbytes;
    int t;
    r = s;
    size = wrap_size(size_reg);
    case (c.op)
      OP_LOAD: r.count = sat_add(s.count, 8);
      OP_RESTART: begin
        r.idx = '0;
        r.bitpos = BitPosW'(7);
        r.count = '0;
      end
      OP_READ: begin
        if (read_takes(c.nbits)) begin
          r.count = sat_add(s.count, -int'(c.nbits));
          pos = int'(s.bitpos) - int'(c.nbits);
          while (pos < 0) begin
            pos += 8;
            r.idx = next_byte(r.idx, size);
          end
          r.bitpos = BitPosW'(pos);
        end
      end
      OP_WIND: begin
        if (c.offset != '0) begin
          p = int'(s.bitpos) - int'(c.offset);
          nbytes = (p >= 0) ? p / 8 : -((-p + 7) / 8);
          r.bitpos = BitPosW'(p - nbytes * 8);
          t = (int'(s.idx) - nbytes) % int'(size);
          if (t < 0) t += int'(size);
          r.idx = IndexW'(t);
          r.count = sat_add(s.count, -int'(c.offset));
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic cmd_t cmd_of(op_e op, int arg0 = 0, int arg1 = 0);
    cmd_t c;
    c.op = op;
    c.addr = IndexW'($urandom);
    c.data = ByteW'($urandom);
    c.nbits = NbitsW'($urandom);
    c.offset = OffsetW'($urandom);
    case (op)
      OP_LOAD: begin
        c.addr = IndexW'(arg0);
        c.data = ByteW'(arg1);
      end
      OP_READ: c.nbits = NbitsW'(arg0);
      OP_WIND: c.offset = OffsetW'(arg0);
      default: ;
    endcase
    return c;
  endfunction

  // Bytes that a read would fetch and that hold nothing yet are loaded first.
  task automatic plan_cmd(cmd_t c);
    logic [IndexW-1:0] b;
    int span;
    if (c.op == OP_READ && read_takes(c.nbits)) begin
      span = bytes_spanned(plan_ptr.bitpos, c.nbits);
      b = plan_ptr.idx;
      for (int k = 0; k < span; k++) begin
        if (!written[b]) plan_cmd(cmd_of(OP_LOAD, b, $urandom_range(0, 255)));
        b = next_byte(b, wrap_size(plan_size));
      end
    end
    cmd_backlog.push_back('{kind: ENTRY_CMD, cmd: c, size: '0});
    if (c.op == OP_LOAD) written[c.addr] = 1'b1;
    plan_ptr = reader_advance(plan_ptr, plan_size, c);
    planned++;
  endtask

  task automatic plan_cfg(logic [SizeW-1:0] size);
    cmd_backlog.push_back('{kind: ENTRY_CFG, cmd: '0, size: size});
    plan_size = size;
  endtask

  task automatic plan_phase(int budget, int sweep);
    int first;
    int pick;
    int run;
    bit swept;
    logic [IndexW-1:0] b;
    first = planned;
    swept = (sweep == 0);
    while (planned - first < budget) begin
      pick = $urandom_range(0, 99);
      if (!swept && planned - first >= budget / 2) begin
        // Long same-direction winds push the count into saturation.
        swept = 1'b1;
        plan_cmd(cmd_of(OP_RESTART));
        for (int k = 0; k < SweepLength; k++) begin
          plan_cmd(cmd_of(OP_WIND, sweep * int'($urandom_range(30000, 32767))));
        end
      end else if (pick < 40) begin
        plan_cmd(cmd_of(OP_READ, $urandom_range(1, 24)));
      end else if (pick < 45) begin
        plan_cmd(cmd_of(OP_READ, $urandom_range(0, 1) ? 0 : $urandom_range(25, 31)));
      end else if (pick < 60) begin
        plan_cmd(cmd_of(OP_LOAD, $urandom_range(0, IndexSpan - 1), $urandom_range(0, 255)));
      end else if (pick < 70) begin
        b = plan_ptr.idx;
        run = $urandom_range(2, 6);
        for (int k = 0; k < run; k++) begin
          plan_cmd(cmd_of(OP_LOAD, b, $urandom_range(0, 255)));
          b = next_byte(b, wrap_size(plan_size));
        end
        for (int k = 0; k < run; k++) plan_cmd(cmd_of(OP_READ, $urandom_range(1, 24)));
      end else if (pick < 82) begin
        plan_cmd(cmd_of(OP_WIND, int'($urandom_range(0, 128)) - 64));
      end else if (pick < 92) begin
        plan_cmd(cmd_of(OP_WIND, $urandom_range(0, 65535)));
      end else if (pick < 98) begin
        plan_cmd(cmd_of(OP_RESTART));
      end else begin
        cmd_backlog.push_back('{kind: ENTRY_DRAIN, cmd: '0, size: '0});
      end
    end
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    if (mismatches <= ReportLimit) $display("%s", msg);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #ClkHalf clk_i = ~clk_i;
  end

  always @(negedge clk_i) begin : driver
    logic nxt_start;
    logic nxt_we;
    entry_t head;
    if (rst_ni && !(start && acc_cnt != sent_cnt)) begin
      nxt_start = 1'b0;
      nxt_we = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_backlog.size() != 0) begin
        head = cmd_backlog[0];
        if (head.kind == ENTRY_CMD) begin
          operation_i <= head.cmd.op;
          byte_index_i <= head.cmd.addr;
          byte_value_i <= head.cmd.data;
          bits_to_read_i <= head.cmd.nbits;
          wind_offset_i <= head.cmd.offset;
          nxt_start = 1'b1;
          sent_cnt++;
          void'(cmd_backlog.pop_front());
          if (steady_left > 0) begin
            steady_left--;
          end else begin
            pick_gap : begin
              int r;
              r = $urandom_range(0, 99);
              if (r < 55) gap_left = 0;
              else if (r < 90) gap_left = $urandom_range(1, 3);
              else gap_left = $urandom_range(8, 40);
              if ($urandom_range(0, 39) == 0) steady_left = $urandom_range(20, 60);
            end
          end
        end else if (expected_status.size() == 0 && !start && !busy) begin
          if (settle < SettleCycles) begin
            settle++;
          end else begin
            settle = 0;
            if (head.kind == ENTRY_CFG) begin
              cfg_data_i <= head.size;
              nxt_we = 1'b1;
            end
            void'(cmd_backlog.pop_front());
          end
        end
      end
      start <= nxt_start;
      cfg_we_i <= nxt_we;
    end
  end

  always @(posedge clk_i) begin : monitor
    cmd_t c;
    status_t want;
    status_t got;
    ptr_t nxt;
    logic [SizeW-1:0] size;
    logic [IndexW-1:0] b;
    logic [63:0] acc;
    logic [ValueW-1:0] value;
    int span;
    if (rst_ni) begin
      if (done_o) begin
        got = '{value: read_value_o, count: bits_available_o, idx: read_byte_position_o,
                bitpos: read_bit_position_o};
        if (expected_status.size() == 0) begin
          note_mismatch($sformatf("Result with no transaction pending: value %06h count %0d",
                                  got.value, got.count));
        end else begin
          want = expected_status.pop_front();
          if (got.value !== want.value || got.count !== want.count ||
              got.idx !== want.idx || got.bitpos !== want.bitpos) begin
            note_mismatch($sformatf(
              "Mismatch: expected value %06h count %0d byte %0d bit %0d, got %06h %0d %0d %0d",
              want.value, want.count, want.idx, want.bitpos,
              got.value, got.count, got.idx, got.bitpos));
          end
        end
      end
      if (cfg_we_i) begin
        model_size = cfg_data_i;
        cfg_writes++;
      end
      if (start && !busy) begin
        c = '{op: op_e'(operation_i), addr: byte_index_i, data: byte_value_i,
              nbits: bits_to_read_i, offset: wind_offset_i};
        size = wrap_size(model_size);
        value = '0;
        nxt = reader_advance(model_ptr, model_size, c);
        if (c.op == OP_READ && read_takes(c.nbits)) begin
          span = bytes_spanned(model_ptr.bitpos, c.nbits);
          b = model_ptr.idx;
          acc = 64'(model_mem[b]);
          for (int k = 1; k < span; k++) begin
            b = next_byte(b, size);
            acc = (acc << 8) | 64'(model_mem[b]);
          end
          value = ValueW'((acc >> (nxt.bitpos + 1)) & ((64'd1 << c.nbits) - 64'd1));
        end
        if (c.op == OP_LOAD) model_mem[c.addr] = c.data;
        model_ptr = nxt;
        expected_status.push_back('{value: value, count: nxt.count, idx: nxt.idx,
                                    bitpos: nxt.bitpos});
        op_seen[c.op]++;
        if (nxt.count == CountHigh) hit_high = 1'b1;
        if (nxt.count == CountLow) hit_low = 1'b1;
        acc_cnt++;
      end
      if (done_o || (start && !busy) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= QuietLimit) begin
          $display("Timeout: no transaction for %0d cycles.", QuietLimit);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin : stimulus
    logic [SizeW-1:0] size_plan[10];
    status_t left;
    rst_ni = 1'b0;
    start = 1'b0;
    cfg_we_i = 1'b0;
    cfg_data_i = '0;
    operation_i = OP_LOAD;
    byte_index_i = '0;
    byte_value_i = '0;
    bits_to_read_i = '0;
    wind_offset_i = '0;
    model_ptr = '{idx: '0, bitpos: BitPosW'(7), count: '0};
    model_size = SizeReset;
    plan_ptr = model_ptr;
    plan_size = SizeReset;
    foreach (model_mem[i]) model_mem[i] = '0;

    plan_cmd(cmd_of(OP_LOAD, 0, 8'hFF));
    plan_cmd(cmd_of(OP_LOAD, IndexSpan - 1, 8'h00));
    plan_cmd(cmd_of(OP_LOAD, 1, 8'hA5));
    plan_cmd(cmd_of(OP_LOAD, 2, 8'h5A));
    plan_cmd(cmd_of(OP_LOAD, 3, 8'h3C));
    plan_cmd(cmd_of(OP_READ, 0));
    plan_cmd(cmd_of(OP_READ, 25));
    plan_cmd(cmd_of(OP_READ, 31));
    plan_cmd(cmd_of(OP_READ, 1));
    plan_cmd(cmd_of(OP_READ, 24));
    plan_cmd(cmd_of(OP_READ, 7));
    plan_cmd(cmd_of(OP_WIND, 0));
    plan_cmd(cmd_of(OP_WIND, -1));
    plan_cmd(cmd_of(OP_WIND, 1));
    plan_cmd(cmd_of(OP_WIND, 32767));
    plan_cmd(cmd_of(OP_WIND, -32768));
    plan_cmd(cmd_of(OP_WIND, -17));
    plan_cmd(cmd_of(OP_RESTART));
    plan_cmd(cmd_of(OP_WIND, -8));
    plan_cmd(cmd_of(OP_READ, 16));
    plan_cmd(cmd_of(OP_READ, 24));
    plan_cmd(cmd_of(OP_LOAD, IndexSpan - 1, 8'hFF));
    plan_cmd(cmd_of(OP_RESTART));

    size_plan = '{SizeW'(0), SizeW'(1), SizeW'(2), SizeW'(17), SizeW'(8191),
                  SizeW'(4096), SizeW'(301), SizeW'(4095), SizeW'(5000), SizeW'(64)};
    foreach (size_plan[i]) begin
      plan_cfg(size_plan[i]);
      plan_phase(PhaseBudget, (i % 3 == 0) ? 1 : (i % 3 == 1) ? -1 : 0);
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_backlog.size() != 0 || start || expected_status.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);
    while (expected_status.size() != 0) begin
      left = expected_status.pop_front();
      note_mismatch($sformatf("Missing result: expected value %06h count %0d byte %0d bit %0d",
                              left.value, left.count, left.idx, left.bitpos));
    end

    $display("Ran %0d transactions (%0d loads, %0d restarts, %0d reads, %0d winds) over %0d sizes.",
             acc_cnt, op_seen[OP_LOAD], op_seen[OP_RESTART], op_seen[OP_READ],
             op_seen[OP_WIND], cfg_writes);
    $display("Count reached its upper limit: %0d, its lower limit: %0d; mismatches: %0d.",
             hit_high, hit_low, mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
